// ===== rtl/dvv_pkg.sv =====
// ----------------------------------------------------------------------------
// dvv_pkg
// Shared types and constants for the DTMF digit vote validator.
// ----------------------------------------------------------------------------
package dvv_pkg;

  localparam int unsigned NUM_KEYS    = 12;
  localparam int unsigned NUM_SYMBOLS = NUM_KEYS + 1;
  localparam int unsigned CODE_W      = 4;
  localparam int unsigned COUNT_W     = 4;

  typedef logic [CODE_W-1:0]  code_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam code_t  SYM_NONE  = code_t'(0);
  localparam count_t COUNT_MAX = '1;

  typedef struct packed {
    logic  new_key;
    code_t key_code;
  } result_t;

  // keys map to themselves, everything else to the no-tone symbol
  function automatic code_t symbol_of(input code_t code);
    if (code >= code_t'(1) && code <= code_t'(NUM_KEYS)) begin
      return code;
    end
    return SYM_NONE;
  endfunction

endpackage

// ===== rtl/dvv_ifs.sv =====
// ----------------------------------------------------------------------------
// dvv_code_if / dvv_key_if
// Valid/ready channels carrying detector codes in and validated keys out.
// ----------------------------------------------------------------------------
interface dvv_code_if;
  logic           valid;
  logic           ready;
  dvv_pkg::code_t detected_code;

  modport source (output valid, output detected_code, input ready);
  modport sink   (input valid, input detected_code, output ready);
endinterface

interface dvv_key_if;
  logic           valid;
  logic           ready;
  logic           new_key;
  dvv_pkg::code_t key_code;

  modport source (output valid, output new_key, output key_code, input ready);
  modport sink   (input valid, input new_key, input key_code, output ready);
endinterface

// ===== rtl/dvv_out_buf.sv =====
// ----------------------------------------------------------------------------
// dvv_out_buf
// Result register with a skid stage; takes a new result while one is stalled.
// ----------------------------------------------------------------------------
module dvv_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dvv_pkg::result_t  push_data,
  output logic              push_ready,
  dvv_key_if.source         keys
);

  logic             out_valid;
  dvv_pkg::result_t out_data;
  logic             skid_valid;
  dvv_pkg::result_t skid_data;

  assign push_ready    = ~skid_valid;
  assign keys.valid    = out_valid;
  assign keys.new_key  = out_data.new_key;
  assign keys.key_code = out_data.key_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (~out_valid | keys.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
        out_data  <= push_data;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_data  <= push_data;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid) else $error("skid holds data with empty output");

  a_push_when_ready: assert property (@(posedge clk) disable iff (rst)
    push |-> push_ready) else $error("result pushed into full buffer");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && keys.ready |=> !skid_valid && out_valid)
    else $error("skid did not move to output");

endmodule

// ===== rtl/dtmf_digit_vote_validator_core.sv =====
// ----------------------------------------------------------------------------
// dtmf_digit_vote_validator_core
// Majority-vote validator for per-frame DTMF key codes.
// Accepts one code per cycle while the result buffer is ready.
// Results are registered; counts update by one evict and one insert.
// A two-entry result buffer keeps input open while one result is stalled.
// Reset: ring all no-tone, no-tone count WINDOW, disarmed, threshold ceil(0.7*WINDOW).
// ----------------------------------------------------------------------------
module dtmf_digit_vote_validator_core #(
  parameter int unsigned WINDOW = 15
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_wr_en,
  input  dvv_pkg::code_t cfg_wr_data,
  dvv_code_if.sink       codes,
  dvv_key_if.source      keys
);

  localparam int unsigned SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned THR_RESET  = (WINDOW * 7 + 9) / 10;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  dvv_pkg::count_t  vote_threshold;
  dvv_pkg::code_t   code_ring [WINDOW];
  logic [SLOT_W-1:0] write_slot;
  dvv_pkg::count_t  symbol_counts      [dvv_pkg::NUM_SYMBOLS];
  dvv_pkg::count_t  symbol_counts_next [dvv_pkg::NUM_SYMBOLS];
  logic             armed;
  logic             armed_next;

  logic             accept;
  logic             buf_ready;
  dvv_pkg::code_t   old_sym;
  dvv_pkg::code_t   new_sym;
  dvv_pkg::code_t   winner;
  dvv_pkg::result_t result;

  assign accept      = codes.valid & buf_ready;
  assign codes.ready = buf_ready;
  assign old_sym     = code_ring[write_slot];
  assign new_sym     = dvv_pkg::symbol_of(codes.detected_code);

  always_comb begin
    dvv_pkg::count_t mid;
    for (int s = 0; s < dvv_pkg::NUM_SYMBOLS; s++) begin
      mid = symbol_counts[s];
      if (old_sym == dvv_pkg::code_t'(s) && mid != '0) begin
        mid = mid - dvv_pkg::count_t'(1);
      end
      if (new_sym == dvv_pkg::code_t'(s) && mid != dvv_pkg::COUNT_MAX) begin
        mid = mid + dvv_pkg::count_t'(1);
      end
      symbol_counts_next[s] = mid;
    end
  end

  always_comb begin
    winner = dvv_pkg::SYM_NONE;
    if (armed) begin
      for (int k = dvv_pkg::NUM_KEYS; k >= 1; k--) begin
        if (symbol_counts_next[k] >= vote_threshold) begin
          winner = dvv_pkg::code_t'(k);
        end
      end
    end
    armed_next = armed & (winner == dvv_pkg::SYM_NONE);
    if (symbol_counts_next[0] >= vote_threshold) begin
      armed_next = 1'b1;
    end
    result.new_key  = (winner != dvv_pkg::SYM_NONE);
    result.key_code = winner;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vote_threshold <= dvv_pkg::count_t'(THR_RESET);
    end else if (cfg_wr_en) begin
      vote_threshold <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        code_ring[i] <= dvv_pkg::SYM_NONE;
      end
      for (int s = 0; s < dvv_pkg::NUM_SYMBOLS; s++) begin
        symbol_counts[s] <= '0;
      end
      symbol_counts[0] <= dvv_pkg::count_t'(WINDOW);
      write_slot       <= '0;
      armed            <= 1'b0;
    end else if (accept) begin
      code_ring[write_slot] <= new_sym;
      symbol_counts         <= symbol_counts_next;
      write_slot            <= (write_slot == SLOT_LAST) ? '0 : write_slot + SLOT_W'(1);
      armed                 <= armed_next;
    end
  end

  dvv_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (result),
    .push_ready (buf_ready),
    .keys       (keys)
  );

  logic [7:0] count_total;
  always_comb begin
    count_total = '0;
    for (int s = 0; s < dvv_pkg::NUM_SYMBOLS; s++) begin
      count_total = count_total + 8'(symbol_counts[s]);
    end
  end

  a_count_total: assert property (@(posedge clk) disable iff (rst)
    count_total == 8'(WINDOW)) else $error("symbol counts do not sum to window");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    write_slot <= SLOT_LAST) else $error("write slot out of range");

  a_key_needs_arm: assert property (@(posedge clk) disable iff (rst)
    accept && result.new_key |-> armed) else $error("key reported while disarmed");

  a_key_disarms: assert property (@(posedge clk) disable iff (rst)
    accept && result.new_key && symbol_counts_next[0] < vote_threshold |=> !armed)
    else $error("key report did not disarm");

endmodule

// ===== test/dtmf_digit_vote_validator_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dtmf_digit_vote_validator_core_test
// Self-checking bench for the DTMF key vote validator. A short table of
// directed codes runs first. Random bursts of silence, held keys and noise
// follow under several vote thresholds and three handshake idling patterns.
// A local vote model predicts each result that the table does not give,
// and each result is compared in order as it leaves the block.
// ----------------------------------------------------------------------------
module dtmf_digit_vote_validator_core_test;

  localparam int unsigned     WINDOW          = 15;
  localparam dvv_pkg::count_t THRESHOLD_RESET =
    dvv_pkg::count_t'((WINDOW * 7 + 9) / 10);
  localparam int              CYCLE_LIMIT     = 400000;
  localparam int              N_DIRECTED      = 20;
  localparam int              N_SEGMENTS      = 6;
  localparam int              SEGMENT_CODES   = 58;

  typedef enum logic {ROW_THRESHOLD, ROW_CODE} row_kind_t;
  typedef enum logic [1:0] {BURST_SILENCE, BURST_KEY, BURST_NOISE} burst_t;

  typedef struct packed {
    row_kind_t        kind;
    dvv_pkg::code_t   value;
    logic             typed;
    dvv_pkg::result_t want;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{ROW_CODE,      4'd0,  1'b1, '{1'b0, 4'd0}},
    '{ROW_CODE,      4'd15, 1'b1, '{1'b0, 4'd0}},
    '{ROW_THRESHOLD, 4'd1,  1'b0, '{1'b0, 4'd0}},
    '{ROW_CODE,      4'd1,  1'b1, '{1'b1, 4'd1}},
    '{ROW_CODE,      4'd12, 1'b0, '{1'b0, 4'd0}},
    '{ROW_CODE,      4'd2,  1'b0, '{1'b0, 4'd0}},
    '{ROW_CODE,      4'd3,  1'b0, '{1'b0, 4'd0}},
    '{ROW_CODE,      4'd13, 1'b0, '{1'b0, 4'd0}},
    '{ROW_CODE,      4'd4,  1'b0, '{1'b0, 4'd0}},
    '{ROW_CODE,      4'd14, 1'b0, '{1'b0, 4'd0}},
    '{ROW_CODE,      4'd5,  1'b0, '{1'b0, 4'd0}},
    '{ROW_CODE,      4'd6,  1'b0, '{1'b0, 4'd0}},
    '{ROW_THRESHOLD, 4'd15, 1'b0, '{1'b0, 4'd0}},
    '{ROW_CODE,      4'd7,  1'b0, '{1'b0, 4'd0}},
    '{ROW_CODE,      4'd8,  1'b0, '{1'b0, 4'd0}},
    '{ROW_CODE,      4'd9,  1'b0, '{1'b0, 4'd0}},
    '{ROW_THRESHOLD, 4'd0,  1'b0, '{1'b0, 4'd0}},
    '{ROW_CODE,      4'd10, 1'b0, '{1'b0, 4'd0}},
    '{ROW_CODE,      4'd11, 1'b1, '{1'b1, 4'd1}},
    '{ROW_THRESHOLD, 4'd11, 1'b0, '{1'b0, 4'd0}}
  };

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           cfg_wr_en;
  dvv_pkg::code_t cfg_wr_data;

  dvv_code_if code_ch ();
  dvv_key_if  key_ch ();

  dtmf_digit_vote_validator_core #(
    .WINDOW(WINDOW)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .codes      (code_ch),
    .keys       (key_ch)
  );

  // vote model state
  dvv_pkg::code_t   tone_ring [WINDOW];
  int unsigned      ring_slot;
  dvv_pkg::count_t  sym_count [dvv_pkg::NUM_SYMBOLS];
  logic             armed;
  dvv_pkg::count_t  vote_threshold;

  dvv_pkg::result_t expected_keys [$];
  int               mismatch_count = 0;
  int               cycle_count = 0;
  int               tx_idle_pct = 0;
  int               rx_idle_pct = 0;

  burst_t           burst_kind;
  int               burst_left = 0;
  dvv_pkg::code_t   burst_key;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic dvv_pkg::result_t vote_on_code(input dvv_pkg::code_t code);
    dvv_pkg::code_t   gone_sym;
    dvv_pkg::code_t   come_sym;
    dvv_pkg::code_t   winner;
    dvv_pkg::result_t res;
    gone_sym = dvv_pkg::symbol_of(tone_ring[ring_slot]);
    come_sym = dvv_pkg::symbol_of(code);
    winner   = dvv_pkg::SYM_NONE;
    if (sym_count[gone_sym] != '0) begin
      sym_count[gone_sym] = sym_count[gone_sym] - dvv_pkg::count_t'(1);
    end
    if (sym_count[come_sym] != dvv_pkg::COUNT_MAX) begin
      sym_count[come_sym] = sym_count[come_sym] + dvv_pkg::count_t'(1);
    end
    tone_ring[ring_slot] = code;
    ring_slot = (ring_slot == WINDOW - 1) ? 0 : ring_slot + 1;
    // armed state is the one from before this code
    if (armed) begin
      for (int k = dvv_pkg::NUM_KEYS; k >= 1; k--) begin
        if (sym_count[k] >= vote_threshold) begin
          winner = dvv_pkg::code_t'(k);
        end
      end
      if (winner != dvv_pkg::SYM_NONE) begin
        armed = 1'b0;
      end
    end
    if (sym_count[dvv_pkg::SYM_NONE] >= vote_threshold) begin
      armed = 1'b1;
    end
    res.new_key  = (winner != dvv_pkg::SYM_NONE);
    res.key_code = winner;
    return res;
  endfunction

  task automatic send_code(input dvv_pkg::code_t code, input logic typed,
                           input dvv_pkg::result_t want);
    dvv_pkg::result_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      code_ch.valid <= 1'b0;
      @(posedge clk);
    end
    code_ch.valid         <= 1'b1;
    code_ch.detected_code <= code;
    @(posedge clk);
    while (!code_ch.ready) begin
      @(posedge clk);
    end
    predicted = vote_on_code(code);
    expected_keys.push_back(typed ? want : predicted);
  endtask

  task automatic drain_keys();
    code_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_keys.size() != 0) begin
      @(posedge clk);
    end
    repeat (2) @(posedge clk);
  endtask

  task automatic set_threshold(input dvv_pkg::count_t value);
    drain_keys();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    vote_threshold  = value;
  endtask

  // silence, held keys with dropouts, and raw noise
  task automatic next_code(output dvv_pkg::code_t code);
    int pick;
    if (burst_left == 0) begin
      pick       = $urandom_range(0, 9);
      burst_left = $urandom_range(1, 24);
      if (pick < 4) begin
        burst_kind = BURST_SILENCE;
      end else if (pick < 8) begin
        burst_kind = BURST_KEY;
      end else begin
        burst_kind = BURST_NOISE;
      end
      burst_key  = dvv_pkg::code_t'($urandom_range(1, dvv_pkg::NUM_KEYS));
    end
    burst_left--;
    case (burst_kind)
      BURST_SILENCE: begin
        pick = $urandom_range(0, 3);
        code = (pick == 0) ? dvv_pkg::SYM_NONE : dvv_pkg::code_t'(dvv_pkg::NUM_KEYS + pick);
      end
      BURST_KEY: begin
        code = ($urandom_range(0, 9) == 0) ? dvv_pkg::code_t'($urandom_range(0, 15))
                                           : burst_key;
      end
      default: begin
        code = dvv_pkg::code_t'($urandom_range(0, 15));
      end
    endcase
  endtask

  always @(posedge clk) begin
    key_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && key_ch.valid && key_ch.ready) begin
      if (expected_keys.size() == 0) begin
        $display("%0t: unexpected transfer new_key=%0b key_code=%0d",
                 $time, key_ch.new_key, key_ch.key_code);
        mismatch_count++;
      end else begin
        if (key_ch.new_key !== expected_keys[0].new_key) begin
          $display("%0t: new_key expected %0b actual %0b",
                   $time, expected_keys[0].new_key, key_ch.new_key);
          mismatch_count++;
        end
        if (key_ch.key_code !== expected_keys[0].key_code) begin
          $display("%0t: key_code expected %0d actual %0d",
                   $time, expected_keys[0].key_code, key_ch.key_code);
          mismatch_count++;
        end
        void'(expected_keys.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    dvv_pkg::code_t code;
    cfg_wr_en             = 1'b0;
    cfg_wr_data           = '0;
    code_ch.valid         = 1'b0;
    code_ch.detected_code = '0;
    key_ch.ready          = 1'b0;
    for (int i = 0; i < WINDOW; i++) begin
      tone_ring[i] = dvv_pkg::SYM_NONE;
    end
    for (int s = 0; s < dvv_pkg::NUM_SYMBOLS; s++) begin
      sym_count[s] = '0;
    end
    sym_count[dvv_pkg::SYM_NONE] = dvv_pkg::count_t'(WINDOW);
    ring_slot                    = 0;
    armed                        = 1'b0;
    vote_threshold               = THRESHOLD_RESET;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < N_DIRECTED; r++) begin
      if (DIRECTED_ROWS[r].kind == ROW_THRESHOLD) begin
        set_threshold(DIRECTED_ROWS[r].value);
      end else begin
        send_code(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          tx_idle_pct = 7;
          rx_idle_pct = 86;
        end
        1: begin
          tx_idle_pct = 86;
          rx_idle_pct = 7;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < N_SEGMENTS; seg++) begin
        case (seg)
          0:       set_threshold(THRESHOLD_RESET);
          1:       set_threshold(dvv_pkg::count_t'(15));
          2:       set_threshold(dvv_pkg::count_t'(1));
          3:       set_threshold(dvv_pkg::count_t'(0));
          default: set_threshold(dvv_pkg::count_t'($urandom_range(2, 14)));
        endcase
        for (int i = 0; i < SEGMENT_CODES; i++) begin
          if (seg == 0 && i == SEGMENT_CODES / 2) begin
            drain_keys();
          end
          next_code(code);
          send_code(code, 1'b0, '0);
        end
      end
    end

    drain_keys();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dvv_pkg.sv
rtl/dvv_ifs.sv
rtl/dvv_out_buf.sv
rtl/dtmf_digit_vote_validator_core.sv
test/dtmf_digit_vote_validator_core_test.sv
